// ===== rtl/bcr_pkg.sv =====
// shared types, codes and constants of the button click recognizer
package bcr_pkg;

  localparam int BUTTONS_DEF     = 4;
  localparam int BACK_BUTTON_DEF = 0;
  localparam int BTN_W           = 3;   // wide enough for any button count up to eight
  localparam int LANES           = 4;   // buttons that own a register lane

  localparam logic [15:0] STD_LONG_DELAY = 16'd750;

  // register indexes
  localparam logic [2:0] REG_REPEAT   = 3'd0;
  localparam logic [2:0] REG_LONG     = 3'd1;
  localparam logic [2:0] REG_TIMEOUT  = 3'd2;
  localparam logic [2:0] REG_LIMITS   = 3'd3;
  localparam logic [2:0] REG_ENABLES  = 3'd4;

  // request kinds
  localparam logic [1:0] REQ_PRESS   = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_TICK    = 2'd2;

  // event codes
  localparam logic [2:0] EV_RAW_DOWN = 3'd0;
  localparam logic [2:0] EV_MULTI    = 3'd1;
  localparam logic [2:0] EV_BACK_POP = 3'd2;
  localparam logic [2:0] EV_CLICK    = 3'd3;
  localparam logic [2:0] EV_RAW_UP   = 3'd4;
  localparam logic [2:0] EV_LONG_REL = 3'd5;
  localparam logic [2:0] EV_REPEAT   = 3'd6;
  localparam logic [2:0] EV_LONG     = 3'd7;

  // handler enable bits within a button's 7-bit group
  localparam int EN_CLICK = 0;
  localparam int EN_MULTI = 1;
  localparam int EN_LONG  = 2;
  localparam int EN_LREL  = 3;
  localparam int EN_RDOWN = 4;
  localparam int EN_RUP   = 5;
  localparam int EN_LAST  = 6;

  // register lanes of one button
  typedef struct packed {
    logic [15:0] rep;
    logic [15:0] ldelay;
    logic [15:0] tmo;
    logic [7:0]  mmin;
    logic [7:0]  mmax;
    logic [6:0]  en;
  } lane_t;

  typedef struct packed {
    logic [2:0]  res;
    logic [1:0]  button;
    logic [15:0] count;
  } event_t;

  typedef struct packed {
    logic emit_ok;
    logic flush_ok;
    logic pend_valid;
  } oq_status_t;

endpackage

// ===== rtl/bcr_sub.sv =====
// shared 32-bit subtractor with borrow, used for time differences and compares
module bcr_sub (
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] diff,
  output logic        borrow
);

  assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

// ===== rtl/bcr_cfg.sv =====
// configuration registers and per-button lane selection
module bcr_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [63:0]               cfg_data,
  input  logic [bcr_pkg::BTN_W-1:0] sel,
  output bcr_pkg::lane_t            lane
);

  logic [63:0] repeat_intervals;
  logic [63:0] long_delays;
  logic [63:0] multi_timeouts;
  logic [63:0] multi_limits;
  logic [27:0] handler_enables;

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_intervals <= '0;
      long_delays      <= {4{bcr_pkg::STD_LONG_DELAY}};
      multi_timeouts   <= '0;
      multi_limits     <= '0;
      handler_enables  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bcr_pkg::REG_REPEAT:  repeat_intervals <= cfg_data;
        bcr_pkg::REG_LONG:    long_delays      <= cfg_data;
        bcr_pkg::REG_TIMEOUT: multi_timeouts   <= cfg_data;
        bcr_pkg::REG_LIMITS:  multi_limits     <= cfg_data;
        bcr_pkg::REG_ENABLES: handler_enables  <= cfg_data[27:0];
        default: ;
      endcase
    end
  end

  logic        in_lane;
  logic [1:0]  ln;
  logic [15:0] ld_raw;
  logic [15:0] lim;

  assign in_lane = (int'(sel) < bcr_pkg::LANES);
  assign ln      = sel[1:0];

  always_comb begin
    ld_raw      = in_lane ? long_delays[16*ln +: 16] : 16'd0;
    lim         = in_lane ? multi_limits[16*ln +: 16] : 16'd0;
    lane.rep    = in_lane ? repeat_intervals[16*ln +: 16] : 16'd0;
    lane.tmo    = in_lane ? multi_timeouts[16*ln +: 16] : 16'd0;
    // a zero lane means the standard delay
    lane.ldelay = (ld_raw == 16'd0) ? bcr_pkg::STD_LONG_DELAY : ld_raw;
    lane.mmin   = lim[7:0];
    lane.mmax   = lim[15:8];
    lane.en     = in_lane ? handler_enables[7*ln +: 7] : 7'd0;
  end

endmodule

// ===== rtl/bcr_outq.sv =====
// one held event plus output register; the held event gets tlast at flush
module bcr_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic                emit,
  input  bcr_pkg::event_t     ev,
  input  logic                flush,
  output bcr_pkg::oq_status_t status,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata,   // event_button[1:0], click_count[17:2]
  output logic [2:0]          m_axis_tuser,   // event_res[2:0]
  output logic                m_axis_tlast
);

  bcr_pkg::event_t pend;
  logic            pend_valid;
  bcr_pkg::event_t obuf;
  logic            slot_free;

  assign slot_free        = !m_axis_tvalid || m_axis_tready;
  assign status.emit_ok   = !pend_valid || slot_free;
  assign status.flush_ok  = !pend_valid || slot_free;
  assign status.pend_valid = pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid    <= 1'b0;
      m_axis_tvalid <= 1'b0;
      m_axis_tlast  <= 1'b0;
    end else begin
      if (emit && status.emit_ok) begin
        // the held event is known not to be the final one
        if (pend_valid) begin
          obuf          <= pend;
          m_axis_tlast  <= 1'b0;
          m_axis_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
          m_axis_tvalid <= 1'b0;
        end
        pend       <= ev;
        pend_valid <= 1'b1;
      end else if (flush && pend_valid && slot_free) begin
        obuf          <= pend;
        m_axis_tlast  <= 1'b1;
        m_axis_tvalid <= 1'b1;
        pend_valid    <= 1'b0;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  assign m_axis_tdata = {6'd0, obuf.count, obuf.button};
  assign m_axis_tuser = obuf.res;

endmodule

// ===== rtl/button_click_recognizer.sv =====
// top level: sequencer over one shared subtractor, per-button state and event output
// a press runs P_CALC, P_DOWN, P_MULTI, P_BACK, a release R_CLICK, R_UP, R_LREL, a tick
// T_DIFF, T_TO per button plus T_REP, T_LONG if pressed, each then FLUSH; events wait for
// the next one, the last for FLUSH; one subtractor does all time differences and compares,
// one step per cycle, but a step stalls while its event cannot be taken by the output
// synchronous reset clears button state, restores register defaults and empties the output
module button_click_recognizer #(
  parameter int BUTTONS     = bcr_pkg::BUTTONS_DEF,
  parameter int BACK_BUTTON = bcr_pkg::BACK_BUTTON_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // button[1:0], now_ms[33:2], stack_deep[34]
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // event_button[1:0], click_count[17:2]
  output logic [2:0]  m_axis_tuser,   // event_res[2:0]
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int IDX_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

  typedef enum logic [3:0] {
    IDLE, P_CALC, P_DOWN, P_MULTI, P_BACK,
    R_CLICK, R_UP, R_LREL,
    T_DIFF, T_TO, T_REP, T_LONG, FLUSH
  } state_t;

  state_t st;

  logic [31:0]        press_time [BUTTONS];
  logic [15:0]        count      [BUTTONS];
  logic [BUTTONS-1:0] pressed;
  logic [BUTTONS-1:0] long_seen;

  logic [IDX_W-1:0] cur;
  logic [31:0]      now_r;
  logic             deep_r;
  logic             handled;
  logic [31:0]      diff_r;

  logic [bcr_pkg::BTN_W-1:0] bext;
  bcr_pkg::lane_t            lane;
  bcr_pkg::event_t           ev;
  bcr_pkg::oq_status_t       oq_st;
  logic                      emit;
  logic                      adv;
  logic                      flush;
  logic [31:0]               sub_a;
  logic [31:0]               sub_b;
  logic [31:0]               sub_diff;
  logic                      sub_borrow;

  logic [2:0] in_b3;
  logic       in_b_ok;
  logic       last_btn;
  logic [15:0] cnt;
  logic       multi_ok;
  logic       rep_hit;
  logic       long_hit;

  assign bext     = bcr_pkg::BTN_W'(cur);
  assign in_b3    = {1'b0, s_axis_tdata[1:0]};
  assign in_b_ok  = (int'(s_axis_tdata[1:0]) < BUTTONS);
  assign last_btn = (cur == IDX_W'(BUTTONS - 1));
  assign cnt      = count[cur];
  assign s_axis_tready = (st == IDLE) && !rst;

  bcr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sel       (bext),
    .lane      (lane)
  );

  bcr_sub u_sub (
    .a      (sub_a),
    .b      (sub_b),
    .diff   (sub_diff),
    .borrow (sub_borrow)
  );

  bcr_outq u_outq (
    .clk           (clk),
    .rst           (rst),
    .emit          (emit),
    .ev            (ev),
    .flush         (flush),
    .status        (oq_st),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // multi-click window on the already incremented count
  always_comb begin
    if (lane.en[bcr_pkg::EN_LAST]) begin
      multi_ok = (lane.mmax != 8'd0) && (cnt == {8'd0, lane.mmax});
    end else begin
      multi_ok = (cnt >= {8'd0, lane.mmin}) &&
                 ((lane.mmax == 8'd0) || (cnt <= {8'd0, lane.mmax}));
    end
  end

  // shared subtractor operands and event selection per step
  always_comb begin
    sub_a     = diff_r;
    sub_b     = {16'd0, lane.rep};
    emit      = 1'b0;
    flush     = 1'b0;
    ev.res    = bcr_pkg::EV_RAW_DOWN;
    ev.button = bext[1:0];
    ev.count  = cnt;
    rep_hit   = lane.en[bcr_pkg::EN_CLICK] && (lane.rep != 16'd0) && !sub_borrow;
    long_hit  = !long_seen[cur] && !sub_borrow;
    case (st)
      P_DOWN: begin
        emit = lane.en[bcr_pkg::EN_RDOWN];
      end
      P_MULTI: begin
        emit   = lane.en[bcr_pkg::EN_MULTI] && multi_ok;
        ev.res = bcr_pkg::EV_MULTI;
      end
      P_BACK: begin
        emit   = !handled && (int'(cur) == BACK_BUTTON) && deep_r;
        ev.res = bcr_pkg::EV_BACK_POP;
      end
      R_CLICK: begin
        emit   = lane.en[bcr_pkg::EN_CLICK] && !long_seen[cur];
        ev.res = bcr_pkg::EV_CLICK;
      end
      R_UP: begin
        emit   = lane.en[bcr_pkg::EN_RUP];
        ev.res = bcr_pkg::EV_RAW_UP;
      end
      R_LREL: begin
        emit   = long_seen[cur] && lane.en[bcr_pkg::EN_LREL];
        ev.res = bcr_pkg::EV_LONG_REL;
      end
      T_DIFF: begin
        sub_a = now_r;
        sub_b = press_time[cur];
      end
      T_TO: begin
        // borrow here means the elapsed time is past the timeout
        sub_a = {16'd0, lane.tmo};
        sub_b = diff_r;
      end
      T_REP: begin
        emit   = rep_hit;
        ev.res = bcr_pkg::EV_REPEAT;
      end
      T_LONG: begin
        sub_b  = {16'd0, lane.ldelay};
        emit   = long_hit && lane.en[bcr_pkg::EN_LONG];
        ev.res = bcr_pkg::EV_LONG;
      end
      FLUSH: begin
        flush = 1'b1;
      end
      default: ;
    endcase
    adv = !emit || oq_st.emit_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= IDLE;
      cur        <= '0;
      handled    <= 1'b0;
      pressed    <= '0;
      long_seen  <= '0;
      press_time <= '{default: '0};
      count      <= '{default: '0};
    end else begin
      case (st)
        IDLE: begin
          if (s_axis_tvalid) begin
            now_r  <= s_axis_tdata[33:2];
            deep_r <= s_axis_tdata[34];
            // a tick walks all buttons from the first one
            cur    <= (s_axis_tuser == bcr_pkg::REQ_TICK) ? '0 : in_b3[IDX_W-1:0];
            case (s_axis_tuser)
              bcr_pkg::REQ_PRESS:   st <= in_b_ok ? P_CALC : IDLE;
              bcr_pkg::REQ_RELEASE: st <= in_b_ok ? R_CLICK : IDLE;
              bcr_pkg::REQ_TICK:    st <= T_DIFF;
              default: st <= IDLE;
            endcase
          end
        end
        P_CALC: begin
          count[cur]      <= cnt + 16'd1;
          press_time[cur] <= now_r;
          pressed[cur]    <= 1'b1;
          handled         <= 1'b0;
          st              <= P_DOWN;
        end
        P_DOWN: begin
          if (adv) begin
            if (emit) handled <= 1'b1;
            st <= P_MULTI;
          end
        end
        P_MULTI: begin
          if (adv) begin
            if (emit) handled <= 1'b1;
            st <= P_BACK;
          end
        end
        P_BACK: begin
          if (adv) st <= FLUSH;
        end
        R_CLICK: begin
          pressed[cur] <= 1'b0;
          if (adv) st <= R_UP;
        end
        R_UP: begin
          if (adv) st <= R_LREL;
        end
        R_LREL: begin
          if (adv) begin
            long_seen[cur] <= 1'b0;
            st             <= FLUSH;
          end
        end
        T_DIFF: begin
          diff_r <= sub_diff;
          st     <= T_TO;
        end
        T_TO: begin
          if ((lane.tmo != 16'd0) && (press_time[cur] != 32'd0) && sub_borrow) begin
            count[cur] <= 16'd0;
          end
          if (pressed[cur]) begin
            st <= T_REP;
          end else if (last_btn) begin
            st <= FLUSH;
          end else begin
            cur <= cur + IDX_W'(1);
            st  <= T_DIFF;
          end
        end
        T_REP: begin
          if (adv) begin
            if (rep_hit) begin
              // restart the interval; a zero difference cannot reach the long delay
              press_time[cur] <= now_r;
              count[cur]      <= cnt + 16'd1;
              diff_r          <= 32'd0;
            end
            st <= T_LONG;
          end
        end
        T_LONG: begin
          if (adv) begin
            if (long_hit) long_seen[cur] <= 1'b1;
            if (last_btn) begin
              st <= FLUSH;
            end else begin
              cur <= cur + IDX_W'(1);
              st  <= T_DIFF;
            end
          end
        end
        FLUSH: begin
          if (oq_st.flush_ok) st <= IDLE;
        end
        default: st <= IDLE;
      endcase
    end
  end

  // a new item only starts with nothing held back
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !oq_st.pend_valid)
    else $error("item accepted while an event is still held");

  // a beat without tlast always has a successor waiting
  a_not_last_has_next: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |-> oq_st.pend_valid)
    else $error("non-final beat with no following event");

  // a release leaves the button with no long press pending
  a_release_clears: assert property (@(posedge clk) disable iff (rst)
    ((st == R_LREL) ##1 (st == FLUSH)) |-> (!long_seen[cur] && !pressed[cur]))
    else $error("release did not clear button state");

  // the tick walk stays inside the button range
  a_cur_range: assert property (@(posedge clk) disable iff (rst)
    (st == T_DIFF) |-> (int'(cur) < BUTTONS))
    else $error("button index out of range");

endmodule

// ===== dv/tb_button_click_recognizer.sv =====
// testbench of the button click recognizer: random press, release and tick beats checked against a predictor
module tb_button_click_recognizer;
  import bcr_pkg::*;

  localparam int NBTN         = BUTTONS_DEF;
  localparam int MAX_BURST    = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 40;

  // request kind that the block has no use for
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // button[1:0], now_ms[33:2], stack_deep[34]
  logic [1:0]  s_axis_tuser;   // req_type[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // event_button[1:0], click_count[17:2]
  logic [2:0]  m_axis_tuser;   // event_res[2:0]
  logic        m_axis_tlast;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_data;

  bit          calm;
  bit          hold_req;
  logic [31:0] now_ms;
  bit          held [NBTN];
  int          stall_cycles;

  typedef struct packed {
    event_t ev;
    logic   last;
  } click_beat_t;

  class click_tracker;
    logic [63:0]  rep_iv;
    logic [63:0]  long_dl;
    logic [63:0]  multi_to;
    logic [63:0]  multi_lim;
    logic [27:0]  enables;
    logic [31:0]  t_press [NBTN];
    bit           down [NBTN];
    logic [15:0]  clicks [NBTN];
    bit           long_hit [NBTN];
    click_beat_t  events_due [$];
    click_beat_t  burst [$];
    int           errors;

    function new();
      rep_iv    = '0;
      long_dl   = {LANES{STD_LONG_DELAY}};
      multi_to  = '0;
      multi_lim = '0;
      enables   = '0;
      for (int b = 0; b < NBTN; b++) begin
        t_press[b]  = '0;
        down[b]     = 1'b0;
        clicks[b]   = '0;
        long_hit[b] = 1'b0;
      end
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        REG_REPEAT:  rep_iv = val;
        REG_LONG:    long_dl = val;
        REG_TIMEOUT: multi_to = val;
        REG_LIMITS:  multi_lim = val;
        REG_ENABLES: enables = val[27:0];
        default: ;
      endcase
    endfunction

    function logic [15:0] lane(logic [63:0] r, int b);
      if (b >= LANES) return '0;
      return r[16*b +: 16];
    endfunction

    function bit armed(int b, int bit_i);
      if (b >= LANES) return 1'b0;
      return enables[7*b + bit_i];
    endfunction

    // an empty delay lane falls back to the standard delay
    function logic [15:0] hold_delay(int b);
      logic [15:0] d;
      d = lane(long_dl, b);
      return (d == '0) ? STD_LONG_DELAY : d;
    endfunction

    function void add(logic [2:0] res, int b, logic [15:0] cnt);
      click_beat_t x;
      x.ev.res    = res;
      x.ev.button = b[1:0];
      x.ev.count  = cnt;
      x.last      = 1'b0;
      if (burst.size() < MAX_BURST) burst.push_back(x);
    endfunction

    function void press(int b, logic [31:0] now, logic deep);
      logic [15:0] c;
      logic [15:0] lim;
      logic [7:0]  mn;
      logic [7:0]  mx;
      bit          handled;
      bit          only_last;
      c         = clicks[b] + 16'd1;
      lim       = lane(multi_lim, b);
      mn        = lim[7:0];
      mx        = lim[15:8];
      only_last = armed(b, EN_LAST);
      handled   = 1'b0;
      clicks[b]  = c;
      t_press[b] = now;
      down[b]    = 1'b1;
      if (armed(b, EN_RDOWN)) begin
        add(EV_RAW_DOWN, b, c);
        handled = 1'b1;
      end
      if (armed(b, EN_MULTI) &&
          ((!only_last && c >= mn && (mx == 0 || c <= mx)) ||
           (only_last && mx != 0 && c == mx))) begin
        add(EV_MULTI, b, c);
        handled = 1'b1;
      end
      if (!handled && b == BACK_BUTTON_DEF && deep) add(EV_BACK_POP, b, c);
    endfunction

    function void release_btn(int b);
      down[b] = 1'b0;
      if (armed(b, EN_CLICK) && !long_hit[b]) add(EV_CLICK, b, clicks[b]);
      if (armed(b, EN_RUP)) add(EV_RAW_UP, b, clicks[b]);
      if (long_hit[b] && armed(b, EN_LREL)) add(EV_LONG_REL, b, clicks[b]);
      long_hit[b] = 1'b0;
    endfunction

    function void scan(logic [31:0] now);
      logic [31:0] gap;
      logic [15:0] tmo;
      logic [15:0] rp;
      for (int b = 0; b < NBTN; b++) begin
        tmo = lane(multi_to, b);
        rp  = lane(rep_iv, b);
        gap = now - t_press[b];
        if (tmo != 0 && t_press[b] != 0 && gap > {16'd0, tmo}) clicks[b] = '0;
        if (down[b]) begin
          // repeat reports the count before it steps
          if (armed(b, EN_CLICK) && rp != 0 && gap >= {16'd0, rp}) begin
            add(EV_REPEAT, b, clicks[b]);
            t_press[b] = now;
            clicks[b]  = clicks[b] + 16'd1;
          end
          gap = now - t_press[b];
          if (!long_hit[b] && gap >= {16'd0, hold_delay(b)}) begin
            if (armed(b, EN_LONG)) add(EV_LONG, b, clicks[b]);
            long_hit[b] = 1'b1;
          end
        end
      end
    endfunction

    function void take_request(logic [1:0] kind, logic [1:0] b, logic [31:0] now,
                               logic deep);
      burst.delete();
      case (kind)
        REQ_PRESS:   if (b < NBTN) press(b, now, deep);
        REQ_RELEASE: if (b < NBTN) release_btn(b);
        REQ_TICK:    scan(now);
        default: ;
      endcase
      if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
      foreach (burst[k]) events_due.push_back(burst[k]);
    endfunction

    function void complain(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void match_event(logic [2:0] res, logic [1:0] b, logic [15:0] cnt,
                              logic last);
      click_beat_t want;
      if (events_due.size() == 0) begin
        complain($sformatf("unexpected event beat res=%0d button=%0d count=%0d last=%0d",
                           res, b, cnt, last));
        return;
      end
      want = events_due.pop_front();
      if (want.ev.res !== res || want.ev.button !== b || want.ev.count !== cnt ||
          want.last !== last)
        complain($sformatf({"event mismatch: expected res=%0d button=%0d count=%0d last=%0d,",
                            " got res=%0d button=%0d count=%0d last=%0d"},
                           want.ev.res, want.ev.button, want.ev.count, want.last,
                           res, b, cnt, last));
    endfunction

    function int pending();
      return events_due.size();
    endfunction
  endclass

  click_tracker tracker;

  button_click_recognizer i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 32);
      end
    end
  end

  // beat monitor and progress watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        tracker.take_request(s_axis_tuser, s_axis_tdata[1:0], s_axis_tdata[33:2],
                             s_axis_tdata[34]);
      if (m_axis_tvalid && m_axis_tready)
        tracker.match_event(m_axis_tuser, m_axis_tdata[1:0], m_axis_tdata[17:2],
                            m_axis_tlast);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_req(input logic [1:0] kind, input logic [1:0] b, input logic [31:0] t,
                          input logic deep);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {5'd0, deep, t, b};
    do @(posedge clk); while (!s_axis_tready);
    if (!calm && $urandom_range(99) < 32) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // stop offering beats and let the block run dry before touching registers
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    // let the monitor record the last accepted beat first
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_regs(input logic [63:0] rp, input logic [63:0] ld, input logic [63:0] to,
                           input logic [63:0] lim, input logic [27:0] en);
    logic [63:0] vals [5];
    vals = '{rp, ld, to, lim, {36'd0, en}};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
      tracker.set_reg(3'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] rand_lanes(input int hi);
    logic [63:0] v;
    for (int k = 0; k < LANES; k++)
      v[16*k +: 16] = ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom_range(hi));
    return v;
  endfunction

  task automatic load_random();
    logic [63:0] lim;
    for (int k = 0; k < LANES; k++)
      lim[16*k +: 16] = {8'($urandom_range(6)), 8'($urandom_range(4))};
    load_regs(rand_lanes(300), rand_lanes(400), rand_lanes(600), lim, 28'($urandom));
  endtask

  // mostly proper press/release pairs with ticks between, a little noise
  task automatic run_phase(input int n);
    int         pick;
    logic [1:0] b;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      b    = 2'($urandom_range(NBTN - 1));
      if (pick < 40) begin
        now_ms += (pick < 3) ? $urandom : $urandom_range(1, 300);
        send_req(REQ_TICK, b, now_ms, 1'($urandom_range(1)));
      end else if (pick < 90) begin
        now_ms += $urandom_range(0, 40);
        if (held[b]) begin
          send_req(REQ_RELEASE, b, now_ms, 1'($urandom_range(1)));
          held[b] = 1'b0;
        end else begin
          send_req(REQ_PRESS, b, now_ms, 1'($urandom_range(1)));
          held[b] = 1'b1;
        end
      end else if (pick < 94) begin
        send_req(REQ_UNUSED, b, $urandom, 1'($urandom_range(1)));
      end else begin
        // press while held, release while up, odd time stamps
        send_req(held[b] ? REQ_PRESS : REQ_RELEASE, b,
                 (pick < 97) ? now_ms - $urandom_range(0, 50) : $urandom,
                 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    tracker = new();
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= REQ_TICK;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_REPEAT;
    cfg_data      <= '0;
    calm     = 1'b0;
    hold_req = 1'b0;
    now_ms   = '0;
    stall_cycles = 0;
    foreach (held[k]) held[k] = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // button 0 has no down or multi handler so a deep press asks for a back pop;
    // its long delay lane is empty and button 3 has a multi timeout
    load_regs({16'd0, 16'd100, 16'd0, 16'd0},
              {16'd30, 16'd200, 16'hFFFF, 16'd0},
              {16'd500, 16'd0, 16'hFFFF, 16'd0},
              {8'hFF, 8'hFF, 8'd0, 8'd1, 8'd3, 8'd2, 8'd0, 8'd0},
              {7'h7F, 7'h7F, 7'h3F, 7'h2D});
    send_req(REQ_TICK,    2'd0, 32'h0000_0000, 1'b0);
    send_req(REQ_PRESS,   2'd0, 32'd10, 1'b1);
    send_req(REQ_PRESS,   2'd0, 32'd20, 1'b0);
    send_req(REQ_RELEASE, 2'd0, 32'd25, 1'b1);
    send_req(REQ_PRESS,   2'd1, 32'hFFFF_FF00, 1'b1);
    send_req(REQ_TICK,    2'd3, 32'h0000_0100, 1'b1);   // time wraps
    send_req(REQ_RELEASE, 2'd1, 32'h0000_0100, 1'b0);
    send_req(REQ_PRESS,   2'd1, 32'h0000_0200, 1'b0);
    send_req(REQ_RELEASE, 2'd1, 32'h0000_0210, 1'b0);
    send_req(REQ_PRESS,   2'd1, 32'h0000_0220, 1'b0);
    send_req(REQ_RELEASE, 2'd1, 32'h0000_0230, 1'b0);
    send_req(REQ_PRESS,   2'd1, 32'h0000_0300, 1'b0);   // above the multi max
    send_req(REQ_PRESS,   2'd2, 32'd1000, 1'b1);
    send_req(REQ_TICK,    2'd0, 32'd1100, 1'b0);        // auto repeat
    send_req(REQ_TICK,    2'd0, 32'd1300, 1'b0);
    send_req(REQ_RELEASE, 2'd2, 32'd1310, 1'b0);
    send_req(REQ_PRESS,   2'd3, 32'd2000, 1'b0);
    send_req(REQ_TICK,    2'd0, 32'd2030, 1'b0);        // long press
    send_req(REQ_RELEASE, 2'd3, 32'd2040, 1'b0);        // long release, no click
    send_req(REQ_UNUSED,  2'd1, 32'hFFFF_FFFF, 1'b1);
    send_req(REQ_TICK,    2'd0, 32'd2600, 1'b0);        // click count timeout
    send_req(REQ_RELEASE, 2'd1, 32'd2610, 1'b0);
    send_req(REQ_PRESS,   2'd0, 32'd3000, 1'b1);
    send_req(REQ_TICK,    2'd0, 32'd3750, 1'b0);        // default long delay
    send_req(REQ_RELEASE, 2'd0, 32'd3760, 1'b0);
    settle();

    now_ms = $urandom;
    load_random();
    run_phase(40);
    settle();

    load_regs('1, '1, '1, '1, '1);
    run_phase(25);
    settle();

    // no idling on either side; the receiver holds off while beats keep coming
    calm = 1'b1;
    load_random();
    run_phase(15);
    hold_req = 1'b1;
    run_phase(25);
    calm = 1'b0;
    settle();

    load_regs('0, '0, '0, '0, '0);
    run_phase(20);
    settle();

    load_random();
    run_phase(25);
    settle();
    run_phase(25);
    settle();

    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
